[rtl/sos_pkg.sv]
// Shared types and constants for the sample order statistics block.
// No dependencies; every other rtl file imports this package.
package sos_pkg;

  localparam int CAPACITY   = 256;
  localparam int CNT_W      = 9;
  localparam int ADDR_W     = 8;
  localparam int DIV_W      = 80;
  localparam int DVSR_W     = 16;
  localparam int MUL_STEPS  = 40;
  localparam int SQRT_STEPS = 32;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RANK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_RANGE      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FINITE = 3'd4
  } status_e;

  typedef enum logic {
    REG_QUANTILE_P = 1'b0,
    REG_SD_MULT    = 1'b1
  } reg_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] sample;
    logic        not_finite;
    logic [7:0]  rank;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [8:0]  count;
    logic [31:0] rank_value;
    logic [31:0] mean_value;
    logic [30:0] std_dev;
    logic [31:0] mean_plus_devs;
    logic        sd_valid;
    logic [31:0] quantile_value;
    logic        q_valid;
  } res_t;

endpackage

[rtl/sample_order_statistics.sv]
// Top level: configuration registers, request decode, queue and engine.
// Depends on sos_pkg; instantiates sos_cmd_fifo and sos_engine.
//
//  channel  | ports                                          | transfer
//  ---------+------------------------------------------------+---------------------
//  request  | op, sample, sample_not_finite, rank            | push && !full
//  result   | status, sample_count, rank_value, mean_value,  | pop && !empty
//           | std_dev, mean_plus_devs, std_dev_valid,        |
//           | quantile_value, quantile_valid                 |
//  config   | cfg_write, cfg_index, cfg_data                 | cfg_write
//
// An insert shifts each larger stored sample up one place and then writes the new
// sample into the gap. A query makes a streaming pass over the store, two serial
// divisions, two 40-step shift-add multiplies and a 32-step square root. A
// two-entry request queue keeps accepting while a result waits.
// rst is synchronous; it empties the store and the queue and restores registers.
module sample_order_statistics import sos_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op,
  input  logic signed [31:0] sample,
  input  logic               sample_not_finite,
  input  logic [7:0]         rank,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [8:0]         sample_count,
  output logic signed [31:0] rank_value,
  output logic signed [31:0] mean_value,
  output logic [30:0]        std_dev,
  output logic signed [31:0] mean_plus_devs,
  output logic               std_dev_valid,
  output logic signed [31:0] quantile_value,
  output logic               quantile_valid,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  logic [16:0]        quantile_p;
  logic signed [23:0] sd_multiplier;
  cmd_t               req;
  cmd_t               q_cmd;
  logic               q_empty;
  logic               q_pop;
  res_t               res;
  logic               res_valid;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quantile_p    <= 17'd32768;
      sd_multiplier <= 24'sd65536;
    end else if (cfg_write) begin
      case (reg_e'(cfg_index))
        REG_QUANTILE_P: quantile_p    <= cfg_data[16:0];
        REG_SD_MULT:    sd_multiplier <= $signed(cfg_data);
        default:        ;
      endcase
    end
  end

  // Pack the request
  always_comb begin
    req.op         = op_e'(op);
    req.sample     = sample;
    req.not_finite = sample_not_finite;
    req.rank       = rank;
  end

  sos_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (req),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  sos_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cmd           (q_cmd),
    .cmd_empty     (q_empty),
    .cmd_pop       (q_pop),
    .quantile_p    (quantile_p),
    .sd_multiplier (sd_multiplier),
    .res           (res),
    .res_valid     (res_valid),
    .res_pop       (pop)
  );

  // Unpack the result
  assign empty          = !res_valid;
  assign status         = res.status;
  assign sample_count   = res.count;
  assign rank_value     = $signed(res.rank_value);
  assign mean_value     = $signed(res.mean_value);
  assign std_dev        = res.std_dev;
  assign mean_plus_devs = $signed(res.mean_plus_devs);
  assign std_dev_valid  = res.sd_valid;
  assign quantile_value = $signed(res.quantile_value);
  assign quantile_valid = res.q_valid;

endmodule

[rtl/sos_cmd_fifo.sv]
// Two-entry request queue between the front end and the engine.
// Depends on sos_pkg for cmd_t and FIFO_DEPTH.
module sos_cmd_fifo import sos_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       slots [FIFO_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'(FIFO_DEPTH));
  assign empty   = (fill == 2'd0);
  assign rd_data = slots[rd_ptr];

  // Store requests and advance pointers
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en && !full) wr_ptr <= ~wr_ptr;
      if (rd_en && !empty) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end

endmodule

[rtl/sos_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on sos_pkg for DIV_W and DVSR_W.
module sos_div import sos_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic [DVSR_W-1:0] rem;
  logic [6:0]        steps;
  logic              busy;
  logic [DVSR_W:0]   cand;
  logic              fits;

  assign cand     = {rem, quotient[DIV_W-1]};
  assign fits     = (cand >= {1'b0, divisor});

  // Shift in one dividend bit and try a subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= 7'(DIV_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? DVSR_W'(cand - {1'b0, divisor}) : cand[DVSR_W-1:0];
        quotient <= {quotient[DIV_W-2:0], fits};
        steps    <= steps - 7'd1;
        if (steps == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/sos_engine.sv]
// Back end: sorted sample store, insertion sort, rank reads and statistics.
// Depends on sos_pkg and instantiates sos_div.
module sos_engine import sos_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic [16:0]        quantile_p,
  input  logic signed [23:0] sd_multiplier,
  output res_t               res,
  output logic               res_valid,
  input  logic               res_pop
);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_RANK_RD, S_RANK_GET, S_SUM,
    S_MEAN_DIV, S_NS2_MUL, S_SQ_MUL, S_VAR_DIV, S_SQRT, S_MPD_MUL, S_MPD_ADD,
    S_Q_START, S_Q_RD1, S_Q_GET1, S_Q_GET2, S_DONE
  } state_t;

  state_t state;

  // store
  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [31:0]       s_ins;
  logic [ADDR_W-1:0] qaddr;
  logic              q_pair;
  logic [31:0]       qa;
  res_t              res_r;
  logic              greater;

  // sums
  logic signed [39:0] s1;
  logic [71:0]        s2;
  logic [63:0]        sqr;
  logic               v1;
  logic               v2;
  logic [31:0]        absx;
  logic [39:0]        abs_s1;

  // shared shift-add multiplier and divider
  logic [DIV_W-1:0]   m_acc;
  logic [DIV_W-1:0]   m_a;
  logic [39:0]        m_b;
  logic [5:0]         m_cnt;
  logic [DIV_W-1:0]   ns2;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVSR_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quotient;
  logic [17:0]        pair_count;

  // square root
  logic [63:0]        sq_v;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [5:0]         sq_cnt;
  logic [64:0]        sq_trial;
  logic [31:0]        mean_q;

  // mean plus deviations, quantile
  logic [23:0]        am;
  logic [54:0]        prod;
  logic signed [40:0] mpd_sum;
  logic [25:0]        np;
  logic [9:0]         qj;
  logic               qfrac;
  logic signed [32:0] qsum;

  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign res_valid = (state == S_DONE);
  assign greater   = $signed(rd_data) > $signed(s_ins);
  assign absx      = rd_data[31] ? 32'(-rd_data) : rd_data;
  assign abs_s1    = s1[39] ? 40'(-s1) : 40'(s1);
  assign sq_trial  = {1'b0, sq_res} + {1'b0, sq_bit};
  assign mean_q    = s1[39] ? 32'(-div_quotient[31:0]) : div_quotient[31:0];
  assign am        = sd_multiplier[23] ? 24'(-sd_multiplier) : 24'(sd_multiplier);
  assign mpd_sum   = sd_multiplier[23]
                     ? 41'($signed(res_r.mean_value)) - $signed({2'b0, prod[54:16]})
                     : 41'($signed(res_r.mean_value)) + $signed({2'b0, prod[54:16]});
  assign np        = 26'(count) * 26'(quantile_p);
  assign qj        = np[25:16];
  assign qfrac     = (np[15:0] != 16'd0) || (count == CNT_W'(1));
  assign qsum      = 33'($signed(qa)) + 33'($signed(rd_data));
  assign pair_count = 18'(count) * 18'(count - CNT_W'(1));

  always_comb begin
    res       = res_r;
    res.count = count;
  end

  // Steer the store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[ADDR_W-1:0];
    mem_wdata = s_ins;
    mem_raddr = idx[ADDR_W-1:0];
    case (state)
      S_INS_RD:  mem_raddr = ADDR_W'(idx - CNT_W'(1));
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = greater ? rd_data : s_ins;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
      end
      S_RANK_RD, S_Q_RD1: mem_raddr = qaddr;
      S_Q_GET1:  mem_raddr = qaddr + ADDR_W'(1);
      default:   mem_raddr = idx[ADDR_W-1:0];
    endcase
  end

  // Store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  sos_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequence each request
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            res_r <= '0;
            case (cmd.op)
              OP_INSERT: begin
                s_ins <= cmd.sample;
                idx   <= count;
                if (cmd.not_finite) begin
                  res_r.status <= ST_NOT_FINITE;
                  state        <= S_DONE;
                end else if (count == CNT_W'(CAPACITY)) begin
                  res_r.status <= ST_FULL;
                  state        <= S_DONE;
                end else if (count == '0) begin
                  state <= S_INS_PUT;
                end else begin
                  state <= S_INS_RD;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              OP_RANK: begin
                qaddr <= cmd.rank;
                if (count == '0) begin
                  res_r.status <= ST_EMPTY;
                  state        <= S_DONE;
                end else if (CNT_W'(cmd.rank) >= count) begin
                  res_r.status <= ST_RANGE;
                  state        <= S_DONE;
                end else begin
                  state <= S_RANK_RD;
                end
              end
              default: begin
                idx <= '0;
                s1  <= '0;
                s2  <= '0;
                v1  <= 1'b0;
                v2  <= 1'b0;
                if (count == '0) begin
                  res_r.status <= ST_EMPTY;
                  state        <= S_DONE;
                end else begin
                  state <= S_SUM;
                end
              end
            endcase
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        // Shift the larger neighbor up, or drop the sample into the gap
        S_INS_CMP: begin
          if (greater) begin
            idx   <= idx - CNT_W'(1);
            state <= (idx == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_INS_PUT: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_RANK_RD: state <= S_RANK_GET;
        S_RANK_GET: begin
          res_r.rank_value <= rd_data;
          state            <= S_DONE;
        end
        // Stream the store through the square and accumulate
        S_SUM: begin
          v1 <= (idx < count);
          if (idx < count) idx <= idx + CNT_W'(1);
          v2 <= v1;
          if (v1) begin
            sqr <= absx * absx;
            s1  <= s1 + 40'($signed(rd_data));
          end
          if (v2) s2 <= s2 + 72'(sqr);
          if (idx >= count && !v1 && !v2) begin
            div_dividend <= DIV_W'(abs_s1);
            div_divisor  <= DVSR_W'(count);
            div_start    <= 1'b1;
            state        <= S_MEAN_DIV;
          end
        end
        S_MEAN_DIV: begin
          if (div_done) begin
            res_r.mean_value     <= mean_q;
            res_r.mean_plus_devs <= mean_q;
            if (count == CNT_W'(1)) begin
              state <= S_Q_START;
            end else begin
              m_acc <= '0;
              m_a   <= DIV_W'(s2);
              m_b   <= 40'(count);
              m_cnt <= 6'(MUL_STEPS);
              state <= S_NS2_MUL;
            end
          end
        end
        S_NS2_MUL, S_SQ_MUL: begin
          if (m_b[0]) m_acc <= m_acc + m_a;
          m_a   <= {m_a[DIV_W-2:0], 1'b0};
          m_b   <= {1'b0, m_b[39:1]};
          m_cnt <= m_cnt - 6'd1;
          if (m_cnt == 6'd0) begin
            if (state == S_NS2_MUL) begin
              ns2   <= m_acc;
              m_acc <= '0;
              m_a   <= DIV_W'(abs_s1);
              m_b   <= abs_s1;
              m_cnt <= 6'(MUL_STEPS);
              state <= S_SQ_MUL;
            end else begin
              div_dividend <= ns2 - m_acc;
              div_divisor  <= pair_count[DVSR_W-1:0];
              div_start    <= 1'b1;
              state        <= S_VAR_DIV;
            end
          end
        end
        S_VAR_DIV: begin
          if (div_done) begin
            sq_v   <= (div_quotient[DIV_W-1:64] != '0) ? '1 : div_quotient[63:0];
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= 6'(SQRT_STEPS);
            state  <= S_SQRT;
          end
        end
        // One result bit per cycle
        S_SQRT: begin
          if (sq_cnt == 6'd0) begin
            res_r.std_dev  <= (sq_res[63:31] != '0) ? '1 : sq_res[30:0];
            res_r.sd_valid <= 1'b1;
            state          <= S_MPD_MUL;
          end else begin
            if ({1'b0, sq_v} >= sq_trial) begin
              sq_v   <= sq_v - sq_trial[63:0];
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
            sq_cnt <= sq_cnt - 6'd1;
          end
        end
        S_MPD_MUL: begin
          prod  <= 55'(am) * 55'(res_r.std_dev);
          state <= S_MPD_ADD;
        end
        S_MPD_ADD: begin
          if (mpd_sum > 41'sd2147483647)
            res_r.mean_plus_devs <= 32'h7FFF_FFFF;
          else if (mpd_sum < -41'sd2147483648)
            res_r.mean_plus_devs <= 32'h8000_0000;
          else
            res_r.mean_plus_devs <= mpd_sum[31:0];
          state <= S_Q_START;
        end
        // Pick one sample or a neighbor pair for the quantile
        S_Q_START: begin
          if (qfrac) begin
            qaddr  <= qj[ADDR_W-1:0];
            q_pair <= 1'b0;
            state  <= (10'(count) > qj) ? S_Q_RD1 : S_DONE;
          end else begin
            qaddr  <= ADDR_W'(qj - 10'd1);
            q_pair <= 1'b1;
            state  <= (qj != 10'd0 && 10'(count) > qj) ? S_Q_RD1 : S_DONE;
          end
        end
        S_Q_RD1: state <= S_Q_GET1;
        S_Q_GET1: begin
          if (q_pair) begin
            qa    <= rd_data;
            state <= S_Q_GET2;
          end else begin
            res_r.quantile_value <= rd_data;
            res_r.q_valid        <= 1'b1;
            state                <= S_DONE;
          end
        end
        S_Q_GET2: begin
          res_r.quantile_value <= qsum[32:1];
          res_r.q_valid        <= 1'b1;
          state                <= S_DONE;
        end
        S_DONE: begin
          if (res_pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("held count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CNT_W'(1) || count == '0))
    else $error("held count moved by more than one");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MEAN_DIV || state == S_VAR_DIV))
    else $error("divider finished with no waiting user");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != S_IDLE)) else $error("request taken but engine idle");

  a_sd_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.sd_valid) |-> (res.status == ST_OK && res.count > CNT_W'(1)))
    else $error("deviation flagged valid without two samples");

endmodule
